FILE: sv/nbat_pkg.sv
// shared types, widths and codes for the neighbor blacklist aging table
package nbat_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int NODE_W   = 2;

    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_W-1:0] REVERT_RESET = 16'd10;
    localparam logic [CFG_W-1:0] EXPIRE_RESET = 16'd30;

    localparam logic [CFG_INDEX_W-1:0] REG_REVERT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPIRE = 1'd1;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LISTED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    localparam logic [NODE_W-1:0] NODE_NONE  = 2'd0;
    localparam logic [NODE_W-1:0] NODE_QUEST = 2'd1;
    localparam logic [NODE_W-1:0] NODE_PROB  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic              set_probable;
        logic [TIME_W-1:0] now_seconds;
    } nbat_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node_state;
    } nbat_res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              probable;
        logic [TIME_W-1:0] stamp;
    } nbat_entry_t;

endpackage

FILE: sv/nbat_mem.sv
// entry memory: one write port, one read port with registered read data
module nbat_mem #(
    parameter int ENTRIES = nbat_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  nbat_pkg::nbat_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_idx,
    output nbat_pkg::nbat_entry_t rd_data
);
    import nbat_pkg::*;

    nbat_entry_t mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

FILE: sv/nbat_engine.sv
// table walker: walks entry memory for defined ops; updates entries and valid bits
module nbat_engine #(
    parameter int ENTRIES = nbat_pkg::ENTRIES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [nbat_pkg::CFG_W-1:0] revert_seconds,
    input  logic [nbat_pkg::CFG_W-1:0] expire_seconds,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  nbat_pkg::nbat_req_t       req,
    output logic                      res_valid,
    input  logic                      res_ready,
    output nbat_pkg::nbat_res_t       res
);
    import nbat_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0]         state_reg, state_next;
    nbat_req_t          req_reg, req_next;
    nbat_res_t          res_reg, res_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               chk_reg, chk_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hit_prob_reg, hit_prob_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    nbat_entry_t        wr_data;
    nbat_entry_t        rd_data;
    logic [TIME_W-1:0]  age;
    logic               chk_valid;
    logic               addr_match;

    nbat_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign age        = req_reg.now_seconds - rd_data.stamp;
    assign chk_valid  = valid_reg[chk_idx_reg];
    assign addr_match = (rd_data.address == req_reg.address);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        rd_idx_next     = rd_idx_reg;
        chk_next        = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_prob_next   = hit_prob_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = chk_idx_reg;
        wr_data.address  = rd_data.address;
        wr_data.probable = 1'b0;
        wr_data.stamp    = req_reg.now_seconds;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next            = req;
                    rd_idx_next         = '0;
                    hit_next            = 1'b0;
                    free_found_next     = 1'b0;
                    res_next.status     = STATUS_OK;
                    res_next.node_state = NODE_NONE;
                    if (req.operation <= OP_SWEEP) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                // issue stage
                if (rd_idx_reg < CNT_W'(ENTRIES) && !hit_reg) begin
                    rd_en        = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    chk_next     = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                // check stage, one slot behind
                if (chk_reg && !hit_reg) begin
                    if (req_reg.operation == OP_SWEEP) begin
                        if (chk_valid) begin
                            if (rd_data.probable) begin
                                if (age > {{(TIME_W-CFG_W){1'b0}}, revert_seconds}) begin
                                    wr_en = 1'b1;
                                end
                            end else if (age > {{(TIME_W-CFG_W){1'b0}}, expire_seconds}) begin
                                valid_next[chk_idx_reg] = 1'b0;
                            end
                        end
                    end else begin
                        if (chk_valid && addr_match) begin
                            hit_next      = 1'b1;
                            hit_idx_next  = chk_idx_reg;
                            hit_prob_next = rd_data.probable;
                        end
                        if (!chk_valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                end
                if (hit_reg) begin
                    state_next = ST_FINISH;
                end else if (rd_idx_reg == CNT_W'(ENTRIES)) begin
                    state_next = (req_reg.operation == OP_SWEEP) ? ST_RESP : ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next       = ST_RESP;
                wr_idx           = hit_idx_reg;
                wr_data.address  = req_reg.address;
                wr_data.probable = 1'b1;
                wr_data.stamp    = req_reg.now_seconds;
                unique case (req_reg.operation)
                    OP_ADD: begin
                        if (hit_reg) begin
                            if (hit_prob_reg) begin
                                res_next.status = STATUS_LISTED;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end else if (free_found_reg) begin
                            wr_en                    = 1'b1;
                            wr_idx                   = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                        end else begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    OP_REMOVE: begin
                        if (hit_reg) begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end else begin
                            res_next.status = STATUS_NO_NODE;
                        end
                    end
                    OP_GET: begin
                        if (hit_reg) begin
                            res_next.node_state = hit_prob_reg ? NODE_PROB : NODE_QUEST;
                        end else begin
                            res_next.status = STATUS_NO_NODE;
                        end
                    end
                    OP_SET: begin
                        if (hit_reg) begin
                            wr_en            = 1'b1;
                            wr_data.probable = req_reg.set_probable;
                        end else begin
                            res_next.status = STATUS_NO_NODE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chk_reg   <= 1'b0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        res_reg        <= res_next;
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_prob_reg   <= hit_prob_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_SCAN || state_reg == ST_FINISH))
        else $error("entry memory written outside scan or finish");

    a_chk_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_reg |-> $past(rd_en))
        else $error("check stage active without a read one cycle earlier");

    a_sweep_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && req_reg.operation == OP_SWEEP) |-> (res.status == STATUS_OK))
        else $error("sweep reported a failure status");

    a_node_state_get: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.node_state != NODE_NONE)
            |-> (res.status == STATUS_OK && req_reg.operation == OP_GET))
        else $error("node state reported outside a successful get");

    a_valid_grows_on_add: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(valid_reg) > $past($countones(valid_reg)))
            |-> $past(state_reg == ST_FINISH && req_reg.operation == OP_ADD))
        else $error("entry became valid outside an add");

endmodule

FILE: sv/neighbor_blacklist_aging_table.sv
// Neighbor blacklist with aging: a table of ENTRIES 48-bit addresses kept in a
// single-port-read entry memory, with valid bits in flip-flops cleared at reset.
// One item is worked on at a time; every operation from add to sweep walks the
// table one slot per cycle through the memory read port; a lookup stops early
// once it hits, and unused operation codes skip the walk.
// The result sits in an output register, so the next item is taken while a
// result still waits for transfer.
// revert_seconds and expire_seconds are written through the cfg port; the user
// must write them only while idle, and the block itself does not enforce it.
module neighbor_blacklist_aging_table #(
    parameter int ENTRIES = nbat_pkg::ENTRIES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[2:0], address[50:3], set_probable[51], now_seconds[83:52], zero fill
    input  logic [nbat_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], node_state[3:2], zero fill
    output logic [nbat_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [nbat_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [nbat_pkg::CFG_W-1:0]       cfg_wr_data
);
    import nbat_pkg::*;

    logic [CFG_W-1:0]     revert_reg, revert_next;
    logic [CFG_W-1:0]     expire_reg, expire_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    nbat_req_t req;
    nbat_res_t res;
    logic      res_valid;
    logic      res_ready;

    assign req.operation    = s_tdata[2:0];
    assign req.address      = s_tdata[50:3];
    assign req.set_probable = s_tdata[51];
    assign req.now_seconds  = s_tdata[83:52];

    nbat_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .revert_seconds (revert_reg),
        .expire_seconds (expire_reg),
        .req_valid      (s_tvalid),
        .req_ready      (s_tready),
        .req            (req),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        revert_next = revert_reg;
        expire_next = expire_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_REVERT: revert_next = cfg_wr_data;
                REG_EXPIRE: expire_next = cfg_wr_data;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W-STATUS_W-NODE_W){1'b0}}, res.node_state, res.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            revert_reg   <= REVERT_RESET;
            expire_reg   <= EXPIRE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            revert_reg   <= revert_next;
            expire_reg   <= expire_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule
